// ===== hdl/multi_stream_ring_sample_buffer_macros.svh =====
// Assertion macros for the multi-stream ring sample buffer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MULTI_STREAM_RING_SAMPLE_BUFFER_MACROS_SVH
`define MULTI_STREAM_RING_SAMPLE_BUFFER_MACROS_SVH

// Antecedent this cycle implies consequent in the next cycle.
`define MSRSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MSRSB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/msrsb_pkg.sv =====
// Shared constants, types and helper functions of the multi-stream ring sample buffer.
// No dependencies.
`timescale 1ns / 1ps

package msrsb_pkg;

    localparam int DEPTH       = 4096;
    localparam int MAX_STREAMS = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int PTR_W     = $clog2(DEPTH + 1);
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int STREAM_W  = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int MEM_DEPTH = MAX_STREAMS * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SAMPLE_W  = 2 * SAMPLE_BITS;

    // Fixed widths of the port fields
    localparam int MODE_W      = 3;
    localparam int STREAM_IN_W = 3;
    localparam int SLOT_IN_W   = 12;
    localparam int FIELD_W     = 16;
    localparam int RANGE_W     = 13;
    localparam int SIZE_REG_W  = 13;
    localparam int COUNT_REG_W = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 6;
    localparam int M_TDATA_W   = 88;
    localparam int M_PAD_W     = M_TDATA_W - 4 * RANGE_W - 2 * FIELD_W;

    localparam logic [SIZE_REG_W-1:0]  SIZE_RESET  = SIZE_REG_W'(4096);
    localparam logic [COUNT_REG_W-1:0] COUNT_RESET = COUNT_REG_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SYNC_WR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ASYNC_WR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SYNC_RD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ASYNC_RD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FETCH    = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified command handed from front to back
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [STREAM_W-1:0] stream;
        logic [SLOT_W-1:0]   slot;
        logic                fetch_ok;
        logic [SAMPLE_W-1:0] sample;
        logic                done;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              full;
    } q_status_t;

    // fifo_size clamped to 1..DEPTH
    function automatic logic [PTR_W-1:0] size_in_use(input logic [SIZE_REG_W-1:0] r);
        logic [PTR_W-1:0] s;
        if (r == '0) begin
            s = PTR_W'(1);
        end else if (32'(r) > DEPTH) begin
            s = PTR_W'(DEPTH);
        end else begin
            s = PTR_W'(r);
        end
        return s;
    endfunction

    function automatic logic stream_active(input logic [STREAM_IN_W-1:0] s,
                                           input logic [COUNT_REG_W-1:0] cnt);
        return (32'(s) < 32'(cnt)) && (32'(s) < MAX_STREAMS);
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [STREAM_W-1:0] s,
                                                   input logic [SLOT_W-1:0] slot);
        return ADDR_W'(32'(s) * DEPTH + 32'(slot));
    endfunction

endpackage

// ===== hdl/msrsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msrsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/msrsb_front.sv =====
// Front end: configuration registers, input decode and classification, command queue.
// Depends on msrsb_pkg.
`timescale 1ns / 1ps

module msrsb_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [msrsb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msrsb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [msrsb_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [msrsb_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                 s_tlast,
    output logic                                 q_valid,
    output msrsb_pkg::cmd_t                      q_entry,
    input  logic                                 q_pop,
    output msrsb_pkg::q_status_t                 q_status,
    output logic [msrsb_pkg::PTR_W-1:0]          size
);

    logic [msrsb_pkg::SIZE_REG_W-1:0]  size_cfg_reg;
    logic [msrsb_pkg::COUNT_REG_W-1:0] count_cfg_reg;

    logic [msrsb_pkg::MODE_W-1:0]      in_mode;
    logic [msrsb_pkg::STREAM_IN_W-1:0] in_stream;
    logic [msrsb_pkg::SLOT_IN_W-1:0]   in_slot;
    logic                              active;
    logic                              keep;
    logic                              push;
    msrsb_pkg::cmd_t                   cmd;

    msrsb_pkg::cmd_t                   q_mem_reg [msrsb_pkg::QUEUE_DEPTH];
    logic                              wr_ptr_reg, wr_ptr_next;
    logic                              rd_ptr_reg, rd_ptr_next;
    logic [msrsb_pkg::QLVL_W-1:0]      level_reg, level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg  <= msrsb_pkg::SIZE_RESET;
            count_cfg_reg <= msrsb_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msrsb_pkg::CFG_IDX_SIZE:  size_cfg_reg  <= cfg_data;
                msrsb_pkg::CFG_IDX_COUNT: count_cfg_reg <= cfg_data[msrsb_pkg::COUNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign size = msrsb_pkg::size_in_use(size_cfg_reg);

    // tuser: mode, stream; tdata: slot_index, sample_real, sample_imag, instant_done
    assign in_mode   = s_tuser[2:0];
    assign in_stream = s_tuser[5:3];
    assign in_slot   = s_tdata[11:0];
    assign active    = msrsb_pkg::stream_active(in_stream, count_cfg_reg);

    // Items that change nothing and answer nothing never enter the queue.
    always_comb
    begin
        unique case (in_mode)
            msrsb_pkg::MODE_SYNC_RD:  keep = 1'b1;
            msrsb_pkg::MODE_SYNC_WR,
            msrsb_pkg::MODE_ASYNC_WR,
            msrsb_pkg::MODE_ASYNC_RD,
            msrsb_pkg::MODE_FETCH:    keep = active;
            default:                  keep = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.mode     = in_mode;
        cmd.stream   = msrsb_pkg::STREAM_W'(in_stream);
        cmd.slot     = msrsb_pkg::SLOT_W'(in_slot);
        cmd.fetch_ok = 32'(in_slot) < 32'(size);
        cmd.sample   = {msrsb_pkg::SAMPLE_BITS'(s_tdata[43:28]),
                        msrsb_pkg::SAMPLE_BITS'(s_tdata[27:12])};
        cmd.done     = s_tdata[44];
        cmd.last     = s_tlast;
    end

    assign s_tready = (level_reg < msrsb_pkg::QLVL_W'(msrsb_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (level_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + msrsb_pkg::QLVL_W'(push) - msrsb_pkg::QLVL_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    assign q_status.level = level_reg;
    assign q_status.full  = !s_tready;

endmodule

// ===== hdl/msrsb_back.sv =====
// Back end: ring pointers, sample memory, range and fetch results, output register.
// Depends on msrsb_pkg and msrsb_ram.
`timescale 1ns / 1ps

module msrsb_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [msrsb_pkg::PTR_W-1:0]      size,
    input  logic                             q_valid,
    input  msrsb_pkg::cmd_t                  q_entry,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [msrsb_pkg::M_TDATA_W-1:0]  m_tdata
);

    typedef struct packed {
        logic [msrsb_pkg::RANGE_W-1:0] p1b;
        logic [msrsb_pkg::RANGE_W-1:0] p1e;
        logic [msrsb_pkg::RANGE_W-1:0] p2b;
        logic [msrsb_pkg::RANGE_W-1:0] p2e;
        logic                          is_fetch;
        logic                          ok;
    } res_t;

    logic [msrsb_pkg::PTR_W-1:0] sh_fill_reg, sh_fill_next;
    logic [msrsb_pkg::PTR_W-1:0] sh_head_reg, sh_head_next;
    logic [msrsb_pkg::PTR_W-1:0] sh_blk_reg,  sh_blk_next;
    logic [msrsb_pkg::PTR_W-1:0] st_fill_reg [msrsb_pkg::MAX_STREAMS];
    logic [msrsb_pkg::PTR_W-1:0] st_fill_next[msrsb_pkg::MAX_STREAMS];
    logic [msrsb_pkg::PTR_W-1:0] st_head_reg [msrsb_pkg::MAX_STREAMS];
    logic [msrsb_pkg::PTR_W-1:0] st_head_next[msrsb_pkg::MAX_STREAMS];
    logic [msrsb_pkg::PTR_W-1:0] st_blk_reg  [msrsb_pkg::MAX_STREAMS];
    logic [msrsb_pkg::PTR_W-1:0] st_blk_next [msrsb_pkg::MAX_STREAMS];

    logic                            b_valid_reg, b_valid_next;
    res_t                            b_res_reg, b_res_next;
    logic                            m_valid_reg, m_valid_next;
    logic [msrsb_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                            need_res;
    logic                            out_free;
    logic                            b_free;
    logic                            b_move;
    logic [msrsb_pkg::PTR_W-1:0]     pos;
    logic [msrsb_pkg::PTR_W-1:0]     rd_head;
    logic [msrsb_pkg::PTR_W-1:0]     rd_fill;
    logic [msrsb_pkg::PTR_W-1:0]     empty2;

    logic                            ram_we;
    logic [msrsb_pkg::ADDR_W-1:0]    ram_waddr;
    logic                            ram_re;
    logic [msrsb_pkg::ADDR_W-1:0]    ram_raddr;
    logic [msrsb_pkg::SAMPLE_W-1:0]  ram_rdata;
    logic [msrsb_pkg::FIELD_W-1:0]   f_real;
    logic [msrsb_pkg::FIELD_W-1:0]   f_imag;

    msrsb_ram #(
        .WIDTH (msrsb_pkg::SAMPLE_W),
        .DEPTH (msrsb_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_entry.sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign need_res = (q_entry.mode == msrsb_pkg::MODE_SYNC_RD)
                   || (q_entry.mode == msrsb_pkg::MODE_ASYNC_RD)
                   || (q_entry.mode == msrsb_pkg::MODE_FETCH);
    assign out_free = !m_valid_reg || m_tready;
    assign b_move   = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || out_free;
    // Writes never wait on the result side; reads and fetches need a free result slot.
    assign q_pop    = q_valid && (!need_res || b_free);

    // Range operands: shared pair for sync read, per-stream pair otherwise
    always_comb
    begin
        if (q_entry.mode == msrsb_pkg::MODE_SYNC_RD)
        begin
            rd_head = sh_head_reg;
            rd_fill = sh_fill_reg;
            empty2  = '0;
        end
        else
        begin
            rd_head = st_head_reg[q_entry.stream];
            rd_fill = st_fill_reg[q_entry.stream];
            empty2  = size;
        end
    end

    always_comb
    begin
        sh_fill_next = sh_fill_reg;
        sh_head_next = sh_head_reg;
        sh_blk_next  = sh_blk_reg;
        st_fill_next = st_fill_reg;
        st_head_next = st_head_reg;
        st_blk_next  = st_blk_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = msrsb_pkg::mem_addr(q_entry.stream, q_entry.slot);
        b_res_next   = b_res_reg;
        b_valid_next = b_move ? 1'b0 : b_valid_reg;
        pos          = '0;

        if (q_entry.mode == msrsb_pkg::MODE_SYNC_WR)
        begin
            pos = (sh_fill_reg >= size) ? '0 : sh_fill_reg;
        end
        else
        begin
            pos = (st_fill_reg[q_entry.stream] >= size) ? '0 : st_fill_reg[q_entry.stream];
        end
        ram_waddr = msrsb_pkg::mem_addr(q_entry.stream, pos[msrsb_pkg::SLOT_W-1:0]);

        if (q_pop)
        begin
            unique case (q_entry.mode)
                msrsb_pkg::MODE_SYNC_WR:
                begin
                    if (sh_blk_reg < size)
                    begin
                        ram_we = 1'b1;
                        if (q_entry.done)
                        begin
                            sh_fill_next = pos + msrsb_pkg::PTR_W'(1);
                            sh_blk_next  = sh_blk_reg + msrsb_pkg::PTR_W'(1);
                        end
                    end
                    if (q_entry.done && q_entry.last)
                    begin
                        sh_blk_next = '0;
                    end
                end
                msrsb_pkg::MODE_ASYNC_WR:
                begin
                    if (st_blk_reg[q_entry.stream] < size)
                    begin
                        ram_we = 1'b1;
                        st_fill_next[q_entry.stream] = pos + msrsb_pkg::PTR_W'(1);
                        st_blk_next[q_entry.stream]  =
                            st_blk_reg[q_entry.stream] + msrsb_pkg::PTR_W'(1);
                    end
                    if (q_entry.last)
                    begin
                        st_blk_next[q_entry.stream] = '0;
                    end
                end
                msrsb_pkg::MODE_SYNC_RD,
                msrsb_pkg::MODE_ASYNC_RD:
                begin
                    b_valid_next        = 1'b1;
                    b_res_next.is_fetch = 1'b0;
                    b_res_next.ok       = 1'b0;
                    b_res_next.p1b      = msrsb_pkg::RANGE_W'(rd_head);
                    if (rd_head < rd_fill)
                    begin
                        b_res_next.p1e = msrsb_pkg::RANGE_W'(rd_fill);
                        b_res_next.p2b = msrsb_pkg::RANGE_W'(empty2);
                        b_res_next.p2e = msrsb_pkg::RANGE_W'(empty2);
                    end
                    else
                    begin
                        b_res_next.p1e = msrsb_pkg::RANGE_W'(size);
                        b_res_next.p2b = '0;
                        b_res_next.p2e = msrsb_pkg::RANGE_W'(rd_fill);
                    end
                    if (q_entry.mode == msrsb_pkg::MODE_SYNC_RD)
                    begin
                        sh_head_next = sh_fill_reg;
                    end
                    else
                    begin
                        st_head_next[q_entry.stream] = st_fill_reg[q_entry.stream];
                    end
                end
                msrsb_pkg::MODE_FETCH:
                begin
                    b_valid_next        = 1'b1;
                    ram_re              = q_entry.fetch_ok;
                    b_res_next.is_fetch = 1'b1;
                    b_res_next.ok       = q_entry.fetch_ok;
                    b_res_next.p1b      = '0;
                    b_res_next.p1e      = '0;
                    b_res_next.p2b      = '0;
                    b_res_next.p2e      = '0;
                end
                default: ;
            endcase
        end
    end

    // Read data stays put until the next fetch, which waits for this one to move on.
    always_comb
    begin
        if (b_res_reg.is_fetch && b_res_reg.ok)
        begin
            f_real = msrsb_pkg::FIELD_W'(ram_rdata[msrsb_pkg::SAMPLE_BITS-1:0]);
            f_imag = msrsb_pkg::FIELD_W'(ram_rdata[msrsb_pkg::SAMPLE_W-1:msrsb_pkg::SAMPLE_BITS]);
        end
        else
        begin
            f_real = '0;
            f_imag = '0;
        end
        m_valid_next = b_move ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        m_data_next  = b_move ? {{msrsb_pkg::M_PAD_W{1'b0}}, f_imag, f_real,
                                 b_res_reg.p2e, b_res_reg.p2b, b_res_reg.p1e, b_res_reg.p1b}
                              : m_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_fill_reg <= '0;
            sh_head_reg <= '0;
            sh_blk_reg  <= '0;
            for (int i = 0; i < msrsb_pkg::MAX_STREAMS; i++)
            begin
                st_fill_reg[i] <= '0;
                st_head_reg[i] <= '0;
                st_blk_reg[i]  <= '0;
            end
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            sh_fill_reg <= sh_fill_next;
            sh_head_reg <= sh_head_next;
            sh_blk_reg  <= sh_blk_next;
            st_fill_reg <= st_fill_next;
            st_head_reg <= st_head_next;
            st_blk_reg  <= st_blk_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_res_reg  <= b_res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hdl/multi_stream_ring_sample_buffer.sv =====
// A result passes the command queue, result register plus memory read, then output register.
// Throughput: one item per cycle unless back-pressure stalls results; a two-entry command
// queue parts input and pointer logic, and writes proceed while a result waits at the output register.
// Reset clears all ring pointers and block counts and loads fifo_size 4096, stream_count 8;
// the sample memory is not cleared, so no clearing pass follows reset.
// Top level; depends on msrsb_pkg, msrsb_front, msrsb_back, msrsb_ram and the macros header.
`timescale 1ns / 1ps
`include "multi_stream_ring_sample_buffer_macros.svh"

module multi_stream_ring_sample_buffer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [msrsb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msrsb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // slot_index[11:0], sample_real[27:12], sample_imag[43:28], instant_done[44], zero pad
    input  logic [msrsb_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[2:0], stream[5:3]
    input  logic [msrsb_pkg::S_TUSER_W-1:0]      s_tuser,
    // block_last
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // part1_begin[12:0], part1_end[25:13], part2_begin[38:26], part2_end[51:39],
    // fetched_real[67:52], fetched_imag[83:68], zero pad
    output logic [msrsb_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic                        q_valid;
    msrsb_pkg::cmd_t             q_entry;
    logic                        q_pop;
    msrsb_pkg::q_status_t        q_status;
    logic [msrsb_pkg::PTR_W-1:0] size;

    msrsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .q_status  (q_status),
        .size      (size)
    );

    msrsb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .size     (size),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A sync range read is always queued, so the queue cannot be empty right after one.
    `MSRSB_ASSERT_NEXT(a_sync_read_queued, s_tvalid && s_tready && (s_tuser[2:0] == msrsb_pkg::MODE_SYNC_RD), q_status.level != '0, "accepted sync read did not reach the queue")
    `MSRSB_ASSERT_SAME(a_pop_nonempty, q_pop, q_valid && !q_status.full || q_valid, "back end popped an empty queue")
    `MSRSB_ASSERT_SAME(a_ready_falls_on_push, $fell(s_tready), $past(s_tvalid), "input ready dropped without an accepted item")

endmodule
